@@ hw/rtl/sit_pkg.sv @@
package sit_pkg;

  // Orientation of an ordered point triplet
  typedef enum logic [1:0] {
    TURN_COL = 2'd0,
    TURN_POS = 2'd1,
    TURN_NEG = 2'd2
  } turn_e;

  // Load strobes for the two stages of an orientation lane
  typedef struct packed {
    logic load_prod;
    logic load_turn;
  } lane_ctl_t;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumCoords = 8;

endpackage

@@ hw/rtl/segment_intersection_test.sv @@
// Channel  | Dir | Payload (low bit up)
// s_axis   | in  | tdata: first_start_x, first_start_y, first_end_x, first_end_y,
//          |     |        second_start_x, second_start_y, second_end_x, second_end_y
// m_axis   | out | tdata: segments_meet, 7 zero bits
//
// One request per cycle sustained while m_axis_tready stays high.
// Stages: input register, differences and box tests, products, cross sign, decision.
// The product stage (two (W+1)x(W+1) multiplies per lane, four lanes) sets the depth.
// Each stage holds a valid bit; a stalled output fills empty stages behind it.
// Reset clears only the valid bits.
module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [8*COORD_WIDTH-1:0] s_axis_tdata,  // 8 coordinates, see table
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata   // [0] segments_meet, [7:1] zero
);

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages:0]   rdy;

  logic signed [W:0] a [sit_pkg::NumLanes];
  logic signed [W:0] b [sit_pkg::NumLanes];
  logic signed [W:0] c [sit_pkg::NumLanes];
  logic signed [W:0] d [sit_pkg::NumLanes];
  logic [sit_pkg::NumLanes-1:0] box_b, box_c_q, box_d_q;
  sit_pkg::turn_e    turn [sit_pkg::NumLanes];
  sit_pkg::lane_ctl_t lane_ctl;
  logic              meet, meet_q;

  // Ready chain: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[NumStages] = m_axis_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Front end: input register, differences and box tests
  sit_prep #(.W(W)) u_prep (
    .clk_i      (clk_i),
    .load_in_i  (rdy[0]),
    .load_diff_i(rdy[1]),
    .tdata_i    (s_axis_tdata),
    .a_o        (a),
    .b_o        (b),
    .c_o        (c),
    .d_o        (d),
    .box_o      (box_b)
  );

  assign lane_ctl.load_prod = rdy[2];
  assign lane_ctl.load_turn = rdy[3];

  // Four orientation lanes
  for (genvar g = 0; g < sit_pkg::NumLanes; g++) begin : g_lane
    sit_orient #(.W(W)) u_orient (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .a_i   (a[g]),
      .b_i   (b[g]),
      .c_i   (c[g]),
      .d_i   (d[g]),
      .turn_o(turn[g])
    );
  end

  // Box test bits follow the lanes
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      box_c_q <= box_b;
    end
    if (rdy[3]) begin
      box_d_q <= box_c_q;
    end
  end

  // General crossing or a collinear point inside the other box
  always_comb begin
    meet = (turn[0] != turn[1]) && (turn[2] != turn[3]);
    for (int k = 0; k < sit_pkg::NumLanes; k++) begin
      meet = meet || (turn[k] == sit_pkg::TURN_COL && box_d_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      meet_q <= meet;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {7'b0, meet_q};

`ifndef SYNTHESIS
  // A free-running output never throttles the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // An accepted request reaches the input register stage next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted request lost at entry");

  // Cross sign stage advances into a free decision stage
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && rdy[4]) |=> vld_q[4])
    else $error("request lost before decision stage");

  // A held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && !rdy[5]) |=> (vld_q[4] && $stable(meet_q)))
    else $error("stalled result changed");
`endif

endmodule

@@ hw/rtl/sit_prep.sv @@
module sit_prep #(
  parameter int unsigned W = 16
) (
  input  logic                 clk_i,
  input  logic                 load_in_i,
  input  logic                 load_diff_i,
  input  logic [8*W-1:0]       tdata_i,
  output logic signed [W:0]    a_o [sit_pkg::NumLanes],
  output logic signed [W:0]    b_o [sit_pkg::NumLanes],
  output logic signed [W:0]    c_o [sit_pkg::NumLanes],
  output logic signed [W:0]    d_o [sit_pkg::NumLanes],
  output logic [sit_pkg::NumLanes-1:0] box_o
);

  localparam int unsigned DW = W + 1;

  logic signed [W-1:0] crd_q [sit_pkg::NumCoords];
  logic signed [W:0]   a_q [sit_pkg::NumLanes];
  logic signed [W:0]   b_q [sit_pkg::NumLanes];
  logic signed [W:0]   c_q [sit_pkg::NumLanes];
  logic signed [W:0]   d_q [sit_pkg::NumLanes];
  logic [sit_pkg::NumLanes-1:0] box_q;

  // Point aliases: first start/end, second start/end
  logic signed [W-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
  assign s1x = crd_q[0];
  assign s1y = crd_q[1];
  assign e1x = crd_q[2];
  assign e1y = crd_q[3];
  assign s2x = crd_q[4];
  assign s2y = crd_q[5];
  assign e2x = crd_q[6];
  assign e2y = crd_q[7];

  // Inclusive range test on one axis, endpoints in either order
  function automatic logic in_span(logic signed [W-1:0] m, logic signed [W-1:0] p,
                                   logic signed [W-1:0] q);
    in_span = (m >= p && m <= q) || (m >= q && m <= p);
  endfunction

  // Input register
  always_ff @(posedge clk_i) begin
    if (load_in_i) begin
      for (int i = 0; i < sit_pkg::NumCoords; i++) begin
        crd_q[i] <= tdata_i[i*W +: W];
      end
    end
  end

  // Endpoint differences and bounding box tests
  always_ff @(posedge clk_i) begin
    if (load_diff_i) begin
      // lanes 0/1: base segment first, third point second start / end
      a_q[0] <= DW'(e1y) - DW'(s1y);
      c_q[0] <= DW'(e1x) - DW'(s1x);
      b_q[0] <= DW'(s2x) - DW'(e1x);
      d_q[0] <= DW'(s2y) - DW'(e1y);
      a_q[1] <= DW'(e1y) - DW'(s1y);
      c_q[1] <= DW'(e1x) - DW'(s1x);
      b_q[1] <= DW'(e2x) - DW'(e1x);
      d_q[1] <= DW'(e2y) - DW'(e1y);
      // lanes 2/3: base segment second, third point first start / end
      a_q[2] <= DW'(e2y) - DW'(s2y);
      c_q[2] <= DW'(e2x) - DW'(s2x);
      b_q[2] <= DW'(s1x) - DW'(e2x);
      d_q[2] <= DW'(s1y) - DW'(e2y);
      a_q[3] <= DW'(e2y) - DW'(s2y);
      c_q[3] <= DW'(e2x) - DW'(s2x);
      b_q[3] <= DW'(e1x) - DW'(e2x);
      d_q[3] <= DW'(e1y) - DW'(e2y);
      box_q[0] <= in_span(s2x, s1x, e1x) && in_span(s2y, s1y, e1y);
      box_q[1] <= in_span(e2x, s1x, e1x) && in_span(e2y, s1y, e1y);
      box_q[2] <= in_span(s1x, s2x, e2x) && in_span(s1y, s2y, e2y);
      box_q[3] <= in_span(e1x, s2x, e2x) && in_span(e1y, s2y, e2y);
    end
  end

  assign a_o   = a_q;
  assign b_o   = b_q;
  assign c_o   = c_q;
  assign d_o   = d_q;
  assign box_o = box_q;

endmodule

@@ hw/rtl/sit_orient.sv @@
module sit_orient #(
  parameter int unsigned W = 16
) (
  input  logic               clk_i,
  input  sit_pkg::lane_ctl_t ctl_i,
  input  logic signed [W:0]  a_i,
  input  logic signed [W:0]  b_i,
  input  logic signed [W:0]  c_i,
  input  logic signed [W:0]  d_i,
  output sit_pkg::turn_e     turn_o
);

  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned SW = PW + 1;

  logic signed [PW-1:0] p_q, q_q;
  logic signed [SW-1:0] xprod;
  sit_pkg::turn_e       turn_q;

  // Exact products of the differences
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      p_q <= PW'(a_i) * PW'(b_i);
      q_q <= PW'(c_i) * PW'(d_i);
    end
  end

  // Cross product sign
  assign xprod = SW'(p_q) - SW'(q_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_turn) begin
      if (xprod == '0) begin
        turn_q <= sit_pkg::TURN_COL;
      end else if (xprod[SW-1]) begin
        turn_q <= sit_pkg::TURN_NEG;
      end else begin
        turn_q <= sit_pkg::TURN_POS;
      end
    end
  end

  assign turn_o = turn_q;

endmodule

@@ test/segment_intersection_test_tb.sv @@
`timescale 1ns / 100ps

module segment_intersection_test_tb;

  localparam int CoordWidth = 16;
  localparam int NumPairs = 1550;
  localparam int unsigned CycleLimit = 500000;

  typedef logic signed [CoordWidth-1:0] coord_t;

  // Packed so that first_start_x lands in the lowest bits of tdata
  typedef struct packed {
    coord_t second_end_y;
    coord_t second_end_x;
    coord_t second_start_y;
    coord_t second_start_x;
    coord_t first_end_y;
    coord_t first_end_x;
    coord_t first_start_y;
    coord_t first_start_x;
  } seg_pair_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_STALLS,
    READY_MASK
  } stall_mode_e;

  // Expected-result store with its own intersection predictor
  class meet_tracker;
    bit          expected_meet[$];
    int unsigned fail_count;
    int unsigned reported;

    // Sign of (qy-py)*(rx-qx) - (qx-px)*(ry-qy), exact at full width
    function sit_pkg::turn_e turn_of(coord_t px, coord_t py, coord_t qx, coord_t qy,
                                     coord_t rx, coord_t ry);
      logic signed [CoordWidth:0]      dy1, dx2, dx1, dy2;
      logic signed [2*CoordWidth+2:0]  xprod;
      dy1 = qy - py;
      dx2 = rx - qx;
      dx1 = qx - px;
      dy2 = ry - qy;
      xprod = dy1 * dx2 - dx1 * dy2;
      if (xprod == '0) return sit_pkg::TURN_COL;
      return xprod[2*CoordWidth+2] ? sit_pkg::TURN_NEG : sit_pkg::TURN_POS;
    endfunction

    // Point m inside the box spanned by a and b, bounds inclusive
    function bit in_bounds(coord_t ax, coord_t ay, coord_t mx, coord_t my,
                           coord_t bx, coord_t by);
      return (mx >= ax || mx >= bx) && (mx <= ax || mx <= bx) &&
             (my >= ay || my >= by) && (my <= ay || my <= by);
    endfunction

    function bit segments_meet(seg_pair_t p);
      sit_pkg::turn_e t1, t2, t3, t4;
      t1 = turn_of(p.first_start_x, p.first_start_y, p.first_end_x, p.first_end_y,
                   p.second_start_x, p.second_start_y);
      t2 = turn_of(p.first_start_x, p.first_start_y, p.first_end_x, p.first_end_y,
                   p.second_end_x, p.second_end_y);
      t3 = turn_of(p.second_start_x, p.second_start_y, p.second_end_x, p.second_end_y,
                   p.first_start_x, p.first_start_y);
      t4 = turn_of(p.second_start_x, p.second_start_y, p.second_end_x, p.second_end_y,
                   p.first_end_x, p.first_end_y);
      return (t1 != t2 && t3 != t4) ||
             (t1 == sit_pkg::TURN_COL && in_bounds(p.first_start_x, p.first_start_y,
                                          p.second_start_x, p.second_start_y,
                                          p.first_end_x, p.first_end_y)) ||
             (t2 == sit_pkg::TURN_COL && in_bounds(p.first_start_x, p.first_start_y,
                                          p.second_end_x, p.second_end_y,
                                          p.first_end_x, p.first_end_y)) ||
             (t3 == sit_pkg::TURN_COL && in_bounds(p.second_start_x, p.second_start_y,
                                          p.first_start_x, p.first_start_y,
                                          p.second_end_x, p.second_end_y)) ||
             (t4 == sit_pkg::TURN_COL && in_bounds(p.second_start_x, p.second_start_y,
                                          p.first_end_x, p.first_end_y,
                                          p.second_end_x, p.second_end_y));
    endfunction

    function void note_request(seg_pair_t p);
      expected_meet.push_back(segments_meet(p));
    endfunction

    function void check_result(logic [7:0] data);
      bit meet;
      if (expected_meet.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result 0x%02h with no request pending", data);
        end
        return;
      end
      meet = expected_meet.pop_front();
      if (data !== {7'b0, meet}) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("segments_meet mismatch: expected 0x%02h, got 0x%02h",
                   {7'b0, meet}, data);
        end
      end
    endfunction

    function int pending();
      return expected_meet.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [8*CoordWidth-1:0]    s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;

  meet_tracker tracker = new();

  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned mode_left;
  int unsigned stall_left;
  logic [7:0]  ready_mask;
  stall_mode_e ready_mode;
  logic        ready_next;

  segment_intersection_test #(
    .COORD_WIDTH(CoordWidth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check accepted results, then pick the next ready value
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    if (mode_left == 0) begin
      ready_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 400);
      ready_mask = 8'($urandom_range(1, 255));
      stall_left = 0;
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: ready_next = 1'b1;
      READY_COIN: ready_next = 1'($urandom_range(0, 1));
      READY_STALLS: begin
        if (stall_left > 0) begin
          stall_left--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 24);
        end
      end
      default: ready_next = ready_mask[cycle_count % 8];
    endcase
    m_axis_tready <= ready_next;
  end

  function automatic seg_pair_t pair_of(int sx1, int sy1, int ex1, int ey1,
                                        int sx2, int sy2, int ex2, int ey2);
    seg_pair_t p;
    p.first_start_x  = coord_t'(sx1);
    p.first_start_y  = coord_t'(sy1);
    p.first_end_x    = coord_t'(ex1);
    p.first_end_y    = coord_t'(ey1);
    p.second_start_x = coord_t'(sx2);
    p.second_start_y = coord_t'(sy2);
    p.second_end_x   = coord_t'(ex2);
    p.second_end_y   = coord_t'(ey2);
    return p;
  endfunction

  // Mix of free, clustered, collinear, degenerate and extreme geometry
  function automatic seg_pair_t random_pair();
    int sel, bx, by, dx, dy, kmax, tmp, i;
    int k[4];
    int c[8];
    int extremes[9] = '{-32768, -32767, -16384, -1, 0, 1, 16383, 32766, 32767};
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      for (i = 0; i < 8; i++) c[i] = $urandom();
    end else if (sel < 50) begin
      // tight cluster: many touching and collinear cases
      bx = int'($urandom_range(0, 60000)) - 30000;
      by = int'($urandom_range(0, 60000)) - 30000;
      for (i = 0; i < 8; i++) c[i] = (i % 2 ? by : bx) + int'($urandom_range(0, 6)) - 3;
    end else if (sel < 90) begin
      // points on one line through (bx, by) with step (dx, dy)
      bx = int'($urandom_range(0, 32000)) - 16000;
      by = int'($urandom_range(0, 32000)) - 16000;
      if ($urandom_range(0, 1)) begin
        dx = int'($urandom_range(0, 30)) - 15;
        dy = int'($urandom_range(0, 30)) - 15;
        kmax = $urandom_range(0, 1) ? 8 : 1000;
      end else begin
        dx = int'($urandom_range(0, 1024)) - 512;
        dy = int'($urandom_range(0, 1024)) - 512;
        kmax = $urandom_range(0, 1) ? 8 : 30;
      end
      for (i = 0; i < 4; i++) k[i] = int'($urandom_range(0, 2 * kmax)) - kmax;
      if (sel >= 80) k[1] = k[0];
      for (i = 0; i < 4; i++) begin
        c[2*i]   = bx + k[i] * dx;
        c[2*i+1] = by + k[i] * dy;
      end
      if (sel < 80) begin
        // second end nudged off the line, or left on it
        c[6] += int'($urandom_range(0, 6)) - 3;
        c[7] += int'($urandom_range(0, 6)) - 3;
      end else if ($urandom_range(0, 1)) begin
        // point segment moved just off the line
        c[0] += 1;
        c[2] += 1;
      end
    end else begin
      for (i = 0; i < 8; i++)
        c[i] = $urandom_range(0, 2) ? extremes[$urandom_range(0, 8)] : int'($urandom());
    end
    // shuffle roles of segments and endpoints
    if ($urandom_range(0, 1)) begin
      for (i = 0; i < 4; i++) begin
        tmp = c[i]; c[i] = c[i+4]; c[i+4] = tmp;
      end
    end
    if ($urandom_range(0, 1)) begin
      tmp = c[0]; c[0] = c[2]; c[2] = tmp;
      tmp = c[1]; c[1] = c[3]; c[3] = tmp;
    end
    return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // Send one request; bursts end in a random gap
  task automatic send_pair(input seg_pair_t pair);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(pair);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Hold off until every expected result is back
  task automatic drain();
    if (tracker.pending() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, crossings, touching, collinear and point segments
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
    send_pair(pair_of(-32768, 32767, 32767, -32768, -32768, -32768, -32767, -32768));
    send_pair(pair_of(0, 0, 100, 0, 0, 1, 100, 1));
    send_pair(pair_of(0, 0, 100, 100, 50, 50, 200, 200));
    send_pair(pair_of(0, 0, 10, 10, 20, 20, 30, 30));
    send_pair(pair_of(0, 0, 10, 0, 10, 0, 20, 5));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 10));
    send_pair(pair_of(0, 0, 10, 0, 5, 1, 5, 10));
    send_pair(pair_of(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(pair_of(3, 4, 3, 4, 0, 0, 6, 6));
    send_pair(pair_of(7, -7, 7, -7, 7, -7, 7, -7));
    send_pair(pair_of(7, -7, 7, -7, 8, -7, 8, -7));
    send_pair(pair_of(-32768, -32768, -1, -1, 0, 0, 32767, 32767));
    send_pair(pair_of(-32768, 0, 0, 0, 0, 0, 32767, 0));
    send_pair(pair_of(5, -32768, 5, 32767, 5, 0, 5, 1));
    send_pair(pair_of(0, 0, 1, 1, 10, 0, 0, 10));
    send_pair(pair_of(-32768, -32767, 32767, 32767, 0, 0, 0, 1));
    send_pair(pair_of(32767, 32767, -32768, -32768, 0, -1, -1, 0));
    send_pair(pair_of(1, 1, -1, -1, -1, 1, 1, -1));
    drain();

    // Random phase with two full hold-offs along the way
    for (int n = 0; n < NumPairs; n++) begin
      if (n == 600 || n == 1100) drain();
      send_pair(random_pair());
    end
    drain();
    repeat (12) @(posedge clk_i);

    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
